>>> hdl/vad_pkg.sv
package vad_pkg;

  // Field widths
  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 8;
  localparam int ANGLE_BITS = FRAC_BITS + 8;

  // Internal number formats
  localparam int ANG_FRAC     = 24;                 // fractional bits of an angle
  localparam int CORDIC_ITERS = 28;
  localparam int NORM_BIT     = 40;                 // normalized magnitude is >= 2^NORM_BIT
  localparam int DIFF_BITS    = COORD_BITS + 1;     // edge vector component
  localparam int MAG_BITS     = COORD_BITS;         // magnitude of an edge component
  localparam int POS_BITS     = $clog2(MAG_BITS);
  localparam int SHIFT_BITS   = $clog2(NORM_BIT + 1);
  localparam int XY_BITS      = NORM_BIT + 5;       // covers CORDIC gain and sqrt(2)
  localparam int Z_BITS       = ANG_FRAC + 10;      // +-(180 + 100) degrees
  localparam int D_BITS       = Z_BITS + 1;         // difference of two directions

  // Pipeline depth
  localparam int PREP_STAGES = 4;
  localparam int FIN_STAGES  = 4;
  localparam int LATENCY     = PREP_STAGES + CORDIC_ITERS + FIN_STAGES;

  localparam logic signed [Z_BITS-1:0] HALF_TURN = Z_BITS'(180) << ANG_FRAC;

  // atan(2^-i) in degrees, ANG_FRAC fractional bits, rounded to nearest
  localparam logic signed [Z_BITS-1:0] ATAN_TAB [CORDIC_ITERS] = '{
    Z_BITS'(754974720), Z_BITS'(445687602), Z_BITS'(235489088), Z_BITS'(119537938),
    Z_BITS'(60000934),  Z_BITS'(30029717),  Z_BITS'(15018523),  Z_BITS'(7509720),
    Z_BITS'(3754917),   Z_BITS'(1877466),   Z_BITS'(938733),    Z_BITS'(469367),
    Z_BITS'(234683),    Z_BITS'(117342),    Z_BITS'(58671),     Z_BITS'(29335),
    Z_BITS'(14668),     Z_BITS'(7334),      Z_BITS'(3667),      Z_BITS'(1833),
    Z_BITS'(917),       Z_BITS'(458),       Z_BITS'(229),       Z_BITS'(115),
    Z_BITS'(57),        Z_BITS'(29),        Z_BITS'(14),        Z_BITS'(7)
  };

  typedef struct packed {
    logic signed [COORD_BITS-1:0] first_x;
    logic signed [COORD_BITS-1:0] first_y;
    logic signed [COORD_BITS-1:0] vertex_x;
    logic signed [COORD_BITS-1:0] vertex_y;
    logic signed [COORD_BITS-1:0] second_x;
    logic signed [COORD_BITS-1:0] second_y;
  } vad_in_t;

  typedef struct packed {
    logic [ANGLE_BITS-1:0] angle_deg_q8;
    logic                  degenerate;
  } vad_out_t;

  // Sideband that travels with each transaction through every stage
  typedef struct packed {
    logic valid;
    logic degen;
  } vad_ctl_t;

  // One CORDIC lane: vector and accumulated direction
  typedef struct packed {
    logic signed [XY_BITS-1:0] x;
    logic signed [XY_BITS-1:0] y;
    logic signed [Z_BITS-1:0]  z;
  } vad_lane_t;

endpackage

>>> hdl/vad_prep.sv
module vad_prep (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  vad_pkg::vad_in_t    pts_i,
  output vad_pkg::vad_ctl_t   ctl_o,
  output vad_pkg::vad_lane_t  lane_o [2]
);

  localparam int DW = vad_pkg::DIFF_BITS;
  localparam int MW = vad_pkg::MAG_BITS;
  localparam int PW = vad_pkg::POS_BITS;
  localparam int SW = vad_pkg::SHIFT_BITS;
  localparam int XW = vad_pkg::XY_BITS;
  localparam int ZW = vad_pkg::Z_BITS;

  // Stage 1: edge vectors and coincidence check
  logic signed [DW-1:0] s1_x_d [2], s1_y_d [2];
  logic signed [DW-1:0] s1_x_q [2], s1_y_q [2];
  logic                 degen_d;
  vad_pkg::vad_ctl_t    s1_ctl_q;

  always_comb begin
    s1_x_d[0] = DW'(pts_i.first_x)  - DW'(pts_i.vertex_x);
    s1_y_d[0] = DW'(pts_i.first_y)  - DW'(pts_i.vertex_y);
    s1_x_d[1] = DW'(pts_i.second_x) - DW'(pts_i.vertex_x);
    s1_y_d[1] = DW'(pts_i.second_y) - DW'(pts_i.vertex_y);
    degen_d = (pts_i.first_x == pts_i.vertex_x && pts_i.first_y == pts_i.vertex_y) ||
              (pts_i.second_x == pts_i.vertex_x && pts_i.second_y == pts_i.vertex_y) ||
              (pts_i.first_x == pts_i.second_x && pts_i.first_y == pts_i.second_y);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_ctl_q <= '0;
    end else begin
      s1_ctl_q <= '{valid: valid_i, degen: degen_d};
    end
  end

  always_ff @(posedge clk_i) begin
    s1_x_q <= s1_x_d;
    s1_y_q <= s1_y_d;
  end

  // Stage 2: fold the left half plane onto the right, take the larger magnitude
  logic signed [DW-1:0] s2_x_d [2], s2_y_d [2];
  logic signed [DW-1:0] s2_x_q [2], s2_y_q [2];
  logic signed [ZW-1:0] s2_z_d [2], s2_z_q [2];
  logic        [MW-1:0] s2_m_d [2], s2_m_q [2];
  vad_pkg::vad_ctl_t    s2_ctl_q;

  always_comb begin
    logic signed [DW-1:0] ay;
    logic signed [DW-1:0] mx;
    logic                 neg;
    for (int l = 0; l < 2; l++) begin
      neg = s1_x_q[l] < 0;
      s2_x_d[l] = neg ? -s1_x_q[l] : s1_x_q[l];
      s2_y_d[l] = neg ? -s1_y_q[l] : s1_y_q[l];
      ay = (s2_y_d[l] < 0) ? -s2_y_d[l] : s2_y_d[l];
      mx = (s2_x_d[l] > ay) ? s2_x_d[l] : ay;
      s2_m_d[l] = mx[MW-1:0];
      // negative x axis itself counts as +180
      if (!neg) begin
        s2_z_d[l] = '0;
      end else if (s1_y_q[l] >= 0) begin
        s2_z_d[l] = vad_pkg::HALF_TURN;
      end else begin
        s2_z_d[l] = -vad_pkg::HALF_TURN;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_ctl_q <= '0;
    end else begin
      s2_ctl_q <= s1_ctl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_x_q <= s2_x_d;
    s2_y_q <= s2_y_d;
    s2_z_q <= s2_z_d;
    s2_m_q <= s2_m_d;
  end

  // Stage 3: find the leading one, derive the normalizing shift
  logic [SW-1:0]        s3_sh_d [2], s3_sh_q [2];
  logic signed [DW-1:0] s3_x_q [2], s3_y_q [2];
  logic signed [ZW-1:0] s3_z_q [2];
  vad_pkg::vad_ctl_t    s3_ctl_q;

  always_comb begin
    logic [PW-1:0] pos;
    for (int l = 0; l < 2; l++) begin
      pos = '0;
      for (int b = 0; b < MW; b++) begin
        if (s2_m_q[l][b]) begin
          pos = PW'(b);
        end
      end
      s3_sh_d[l] = SW'(vad_pkg::NORM_BIT) - SW'(pos);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_ctl_q <= '0;
    end else begin
      s3_ctl_q <= s2_ctl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_sh_q <= s3_sh_d;
    s3_x_q  <= s2_x_q;
    s3_y_q  <= s2_y_q;
    s3_z_q  <= s2_z_q;
  end

  // Stage 4: normalize into the CORDIC word
  vad_pkg::vad_lane_t s4_lane_d [2], s4_lane_q [2];
  vad_pkg::vad_ctl_t  s4_ctl_q;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      s4_lane_d[l].x = XW'(s3_x_q[l]) <<< s3_sh_q[l];
      s4_lane_d[l].y = XW'(s3_y_q[l]) <<< s3_sh_q[l];
      s4_lane_d[l].z = s3_z_q[l];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_ctl_q <= '0;
    end else begin
      s4_ctl_q <= s3_ctl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s4_lane_q <= s4_lane_d;
  end

  assign ctl_o  = s4_ctl_q;
  assign lane_o = s4_lane_q;

endmodule

>>> hdl/vad_cordic.sv
module vad_cordic (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  vad_pkg::vad_ctl_t         ctl_i,
  input  vad_pkg::vad_lane_t        lane_i [2],
  output vad_pkg::vad_ctl_t         ctl_o,
  output logic signed [vad_pkg::Z_BITS-1:0] z_o [2]
);

  localparam int CI = vad_pkg::CORDIC_ITERS;
  localparam int XW = vad_pkg::XY_BITS;

  vad_pkg::vad_lane_t stage_q [CI][2];
  vad_pkg::vad_ctl_t  ctl_q   [CI];

  // One vectoring iteration per register stage, both lanes side by side
  for (genvar i = 0; i < CI; i++) begin : g_iter
    vad_pkg::vad_lane_t src [2];
    vad_pkg::vad_ctl_t  src_ctl;
    vad_pkg::vad_lane_t nxt_d [2];

    if (i == 0) begin : g_first
      assign src     = lane_i;
      assign src_ctl = ctl_i;
    end else begin : g_rest
      assign src     = stage_q[i-1];
      assign src_ctl = ctl_q[i-1];
    end

    always_comb begin
      logic signed [XW-1:0] x, y, xs, ys;
      for (int l = 0; l < 2; l++) begin
        x  = src[l].x;
        y  = src[l].y;
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          nxt_d[l].x = x + ys;
          nxt_d[l].y = y - xs;
          nxt_d[l].z = src[l].z + vad_pkg::ATAN_TAB[i];
        end else begin
          nxt_d[l].x = x - ys;
          nxt_d[l].y = y + xs;
          nxt_d[l].z = src[l].z - vad_pkg::ATAN_TAB[i];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[i] <= '0;
      end else begin
        ctl_q[i] <= src_ctl;
      end
    end

    always_ff @(posedge clk_i) begin
      stage_q[i] <= nxt_d;
    end
  end

  assign ctl_o  = ctl_q[CI-1];
  assign z_o[0] = stage_q[CI-1][0].z;
  assign z_o[1] = stage_q[CI-1][1].z;

  // x starts non-negative and only grows; a negative x means a lost sign
  a_x_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_q[CI-1].valid |-> (stage_q[CI-1][0].x >= 0) && (stage_q[CI-1][1].x >= 0))
    else $error("CORDIC x went negative");

endmodule

>>> hdl/vad_finish.sv
module vad_finish (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  vad_pkg::vad_ctl_t                 ctl_i,
  input  logic signed [vad_pkg::Z_BITS-1:0] zu_i,
  input  logic signed [vad_pkg::Z_BITS-1:0] zv_i,
  output logic                              res_valid_o,
  output vad_pkg::vad_out_t                 res_o
);

  localparam int DW  = vad_pkg::D_BITS;
  localparam int AW  = vad_pkg::ANGLE_BITS;
  localparam int SHR = vad_pkg::ANG_FRAC - vad_pkg::FRAC_BITS;

  localparam logic signed [DW-1:0] HALF      = DW'(vad_pkg::HALF_TURN);
  localparam logic signed [DW-1:0] FULL      = HALF <<< 1;
  localparam logic signed [DW-1:0] RND       = DW'(1) <<< (SHR - 1);
  localparam logic [AW-1:0]        ANGLE_MAX = AW'(180) << vad_pkg::FRAC_BITS;

  // F1: difference of the directions
  logic signed [DW-1:0] d_q;
  vad_pkg::vad_ctl_t    f1_ctl_q;
  // F2: magnitude
  logic signed [DW-1:0] ad_q;
  vad_pkg::vad_ctl_t    f2_ctl_q;
  // F3: fold into 0..180
  logic signed [DW-1:0] fold_d, fold_q;
  vad_pkg::vad_ctl_t    f3_ctl_q;
  // F4: round and drive the result
  logic signed [DW-1:0] rnd_sum;
  vad_pkg::vad_out_t    res_d, res_q;
  logic                 res_valid_q;

  assign fold_d  = (ad_q > HALF) ? (FULL - ad_q) : ad_q;
  assign rnd_sum = fold_q + RND;

  always_comb begin
    res_d.degenerate   = f3_ctl_q.degen;
    res_d.angle_deg_q8 = f3_ctl_q.degen ? '0 : rnd_sum[SHR +: AW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_ctl_q    <= '0;
      f2_ctl_q    <= '0;
      f3_ctl_q    <= '0;
      res_valid_q <= 1'b0;
    end else begin
      f1_ctl_q    <= ctl_i;
      f2_ctl_q    <= f1_ctl_q;
      f3_ctl_q    <= f2_ctl_q;
      res_valid_q <= f3_ctl_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    d_q    <= DW'(zu_i) - DW'(zv_i);
    ad_q   <= (d_q < 0) ? -d_q : d_q;
    fold_q <= fold_d;
    res_q  <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.degenerate |-> res_q.angle_deg_q8 == '0)
    else $error("degenerate result with nonzero angle");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> res_q.angle_deg_q8 <= ANGLE_MAX)
    else $error("angle above 180 degrees");

endmodule

>>> hdl/vertex_angle_degrees_unit.sv
// Channel   Direction  Handshake                      Payload
// command   in         start_i, taken when !busy_o    pts_i   (vad_in_t: three points)
// result    out        res_valid_o, one-cycle strobe  res_o   (vad_out_t: angle, degenerate)
//
// Every transaction passes from start_i to res_valid_o through these stages:
// 4 stages of setup (edge vectors, half-plane fold, leading-one search,
// normalizing shift), 28 CORDIC stages (one vectoring iteration each, both
// edge vectors in parallel lanes) and 4 finishing stages (difference, magnitude,
// fold, round). A new transaction enters in every cycle; busy_o stays low.
// Reset clears only the valid and degen bits of the stages; data registers have no reset.
// The receiver cannot stall, so results leave on a fixed schedule and no
// transaction is held, dropped or repeated.
module vertex_angle_degrees_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  vad_pkg::vad_in_t  pts_i,
  output logic              res_valid_o,
  output vad_pkg::vad_out_t res_o
);

  vad_pkg::vad_ctl_t  prep_ctl;
  vad_pkg::vad_lane_t prep_lane [2];
  vad_pkg::vad_ctl_t  cordic_ctl;
  logic signed [vad_pkg::Z_BITS-1:0] dir_z [2];
  logic               accept;

  // The pipeline never stops, so a command is always taken
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // Form edge vectors, flag coincident points, normalize for the CORDIC
  vad_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .pts_i   (pts_i),
    .ctl_o   (prep_ctl),
    .lane_o  (prep_lane)
  );

  // Direction of each edge vector
  vad_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (prep_ctl),
    .lane_i (prep_lane),
    .ctl_o  (cordic_ctl),
    .z_o    (dir_z)
  );

  // Angle between the directions, folded and rounded to the output format
  vad_finish u_finish (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (cordic_ctl),
    .zu_i        (dir_z[0]),
    .zv_i        (dir_z[1]),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  // Each accepted command yields its result on res_valid_o
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##(vad_pkg::LATENCY) res_valid_o)
    else $error("result missing after fixed latency");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(accept, vad_pkg::LATENCY))
    else $error("result without a matching command");

endmodule
